/* hdl/atbd_pkg.sv */
// Shared types, constants and helpers for the argmax threshold box decoder.
`timescale 1ns / 1ps

package atbd_pkg;

  localparam int unsigned MaxClassesDef = 256;
  localparam int unsigned ExpDepth      = 256;
  localparam int unsigned ExpAddrW      = 8;
  localparam int unsigned WordW         = 32;
  localparam int unsigned CfgAddrW      = 5;
  localparam int unsigned EdgeW         = 60;

  localparam logic [WordW-1:0] ThresholdRst = 32'd0;
  localparam logic             SkipBgRst    = 1'b0;
  localparam logic [WordW-1:0] SizeScaleRst = 32'd256;
  localparam logic [WordW-1:0] OffScaleRst  = 32'd1024;
  localparam logic [WordW-1:0] CtrScaleRst  = 32'd65536;

  localparam logic [WordW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] SatMin = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_THRESHOLD  = 3'd0,
    REG_SKIP_BG    = 3'd1,
    REG_SIZE_SCALE = 3'd2,
    REG_OFF_SCALE  = 3'd3,
    REG_CTR_SCALE  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_EDGE,
    ST_OUT
  } state_e;

  function automatic logic [ExpAddrW-1:0] slot_of(input logic [ExpAddrW-1:0] idx);
    slot_of = idx ^ {1'b1, {(ExpAddrW-1){1'b0}}};
  endfunction

  function automatic logic [WordW-1:0] sat32(input logic signed [EdgeW-1:0] v);
    if (!v[EdgeW-1] && (|v[EdgeW-2:WordW-1])) begin
      sat32 = SatMax;
    end else if (v[EdgeW-1] && !(&v[EdgeW-2:WordW-1])) begin
      sat32 = SatMin;
    end else begin
      sat32 = v[WordW-1:0];
    end
  endfunction

endpackage

/* hdl/argmax_threshold_box_decode.sv */
// Top level: running argmax over class scores, threshold test and box decode.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | kind, table_index, value, geometry
//   out     | output    | out_valid_o / out_stall_i | box edges, best_class, best_score
//   cfg     | input     | APB psel/penable/pready   | five 32-bit registers at 4*i
//
// A table word, a score and a failing box are taken while the block stays idle.
// A passing box stalls the input through the exp table read, then the chain of 40x32
// width/height products split into two partial products, then the edge sums.
// Reset clears control and the running maximum; the exp table is undefined until written.
// A finished word waits in the output register while the next items are taken.
`timescale 1ns / 1ps

module argmax_threshold_box_decode
  import atbd_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = MaxClassesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [WordW-1:0]    pwdata,
  output logic [WordW-1:0]    prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic signed [7:0]   table_index_i,
  input  logic [WordW-1:0]    value_i,
  input  logic                last_class_i,
  input  logic signed [7:0]   loc_x_i,
  input  logic signed [7:0]   loc_y_i,
  input  logic signed [7:0]   loc_w_i,
  input  logic signed [7:0]   loc_h_i,
  input  logic [7:0]          prior_cx_i,
  input  logic [7:0]          prior_cy_i,
  input  logic [7:0]          prior_w_i,
  input  logic [7:0]          prior_h_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [WordW-1:0] box_x_min_o,
  output logic signed [WordW-1:0] box_y_min_o,
  output logic signed [WordW-1:0] box_x_max_o,
  output logic signed [WordW-1:0] box_y_max_o,
  output logic [7:0]          best_class_o,
  output logic [WordW-1:0]    best_score_o
);

  localparam int unsigned CntW = $clog2(MAX_CLASSES + 1);
  localparam int unsigned ExtW = (CntW > 8) ? CntW : 8;

  // configuration
  logic [WordW-1:0] thr_q, size_q, off_q, ctr_q;
  logic             skip_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThresholdRst;
      skip_q <= SkipBgRst;
      size_q <= SizeScaleRst;
      off_q  <= OffScaleRst;
      ctr_q  <= CtrScaleRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD:  thr_q  <= pwdata;
        REG_SKIP_BG:    skip_q <= pwdata[0];
        REG_SIZE_SCALE: size_q <= pwdata;
        REG_OFF_SCALE:  off_q  <= pwdata;
        REG_CTR_SCALE:  ctr_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD:  prdata = thr_q;
      REG_SKIP_BG:    prdata = {{(WordW-1){1'b0}}, skip_q};
      REG_SIZE_SCALE: prdata = size_q;
      REG_OFF_SCALE:  prdata = off_q;
      REG_CTR_SCALE:  prdata = ctr_q;
      default:        prdata = '0;
    endcase
  end

  // running argmax
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] best_q, best_d;
  logic [7:0]       bcls_q, bcls_d;
  logic [ExtW-1:0]  cnt_ext;
  logic             accept, score_in, box_end, emit, counted;

  assign accept   = in_valid_i & ~in_stall_o;
  assign score_in = accept & kind_i;
  assign box_end  = score_in & last_class_i;
  assign cnt_ext  = ExtW'(cnt_q);
  assign counted  = (32'(cnt_q) < MAX_CLASSES) && !(skip_q && (cnt_q == '0));

  always_comb begin
    best_d = best_q;
    bcls_d = bcls_q;
    cnt_d  = cnt_q;
    if (32'(cnt_q) < MAX_CLASSES) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (counted && (value_i > best_q)) begin
      best_d = value_i;
      bcls_d = cnt_ext[7:0] - {7'b0, skip_q};
    end
  end

  assign emit = box_end && (best_d >= thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      best_q <= '0;
      bcls_q <= '0;
    end else if (box_end) begin
      cnt_q  <= '0;
      best_q <= '0;
      bcls_q <= '0;
    end else if (score_in) begin
      cnt_q  <= cnt_d;
      best_q <= best_d;
      bcls_q <= bcls_d;
    end
  end

  // exp table
  logic [WordW-1:0] exp_mem [ExpDepth];
  logic [WordW-1:0] expw_q, exph_q;

  always_ff @(posedge clk_i) begin
    if (accept && !kind_i) begin
      exp_mem[slot_of(table_index_i)] <= value_i;
    end
    if (emit) begin
      expw_q <= exp_mem[slot_of(loc_w_i)];
      exph_q <= exp_mem[slot_of(loc_h_i)];
    end
  end

  // sequencer
  state_e state_q, state_d;
  logic   out_valid_q, out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (emit) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_SUM;
      ST_SUM:  state_d = ST_EDGE;
      ST_EDGE: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // decode datapath
  logic signed [7:0] lx_q, ly_q;
  logic [7:0]        pcx_q, pcy_q, pw_q, ph_q;
  logic [WordW-1:0]  rs_score_q;
  logic [7:0]        rs_cls_q;
  logic [39:0]       ww_q, wh_q, cxp_q, cyp_q;
  logic [15:0]       magx_q, magy_q;
  logic              negx_q, negy_q;
  logic [63:0]       wlo_q, hlo_q;
  logic [39:0]       whi_q, hhi_q;
  logic [47:0]       xprod_q, yprod_q;
  logic [56:0]       wd_q, hd_q;
  logic signed [32:0] xo_q, yo_q;
  logic signed [EdgeW-1:0] xmin_q, ymin_q, xmax, ymax, w_half, h_half;
  logic [7:0]        absx, absy;

  assign absx   = lx_q[7] ? 8'(-lx_q) : 8'(lx_q);
  assign absy   = ly_q[7] ? 8'(-ly_q) : 8'(ly_q);
  assign w_half = $signed(EdgeW'(wd_q[56:1]));
  assign h_half = $signed(EdgeW'(hd_q[56:1]));
  assign xmax   = xmin_q + $signed(EdgeW'(wd_q));
  assign ymax   = ymin_q + $signed(EdgeW'(hd_q));

  always_ff @(posedge clk_i) begin
    if (emit) begin
      lx_q       <= loc_x_i;
      ly_q       <= loc_y_i;
      pcx_q      <= prior_cx_i;
      pcy_q      <= prior_cy_i;
      pw_q       <= prior_w_i;
      ph_q       <= prior_h_i;
      rs_score_q <= best_d;
      rs_cls_q   <= bcls_d;
    end
    case (state_q)
      ST_MUL1: begin
        ww_q   <= 40'(pw_q) * 40'(expw_q);
        wh_q   <= 40'(ph_q) * 40'(exph_q);
        cxp_q  <= 40'(pcx_q) * 40'(ctr_q);
        cyp_q  <= 40'(pcy_q) * 40'(ctr_q);
        magx_q <= 16'(absx) * 16'(pw_q);
        magy_q <= 16'(absy) * 16'(ph_q);
        negx_q <= lx_q[7];
        negy_q <= ly_q[7];
      end
      ST_MUL2: begin
        wlo_q   <= 64'(ww_q[31:0]) * 64'(size_q);
        whi_q   <= 40'(ww_q[39:32]) * 40'(size_q);
        hlo_q   <= 64'(wh_q[31:0]) * 64'(size_q);
        hhi_q   <= 40'(wh_q[39:32]) * 40'(size_q);
        xprod_q <= 48'(magx_q) * 48'(off_q);
        yprod_q <= 48'(magy_q) * 48'(off_q);
      end
      ST_SUM: begin
        wd_q <= {1'b0, whi_q, 16'b0} + 57'(wlo_q[63:16]);
        hd_q <= {1'b0, hhi_q, 16'b0} + 57'(hlo_q[63:16]);
        xo_q <= negx_q ? -$signed({1'b0, xprod_q[47:16]}) : $signed({1'b0, xprod_q[47:16]});
        yo_q <= negy_q ? -$signed({1'b0, yprod_q[47:16]}) : $signed({1'b0, yprod_q[47:16]});
      end
      ST_EDGE: begin
        xmin_q <= $signed(EdgeW'(cxp_q[39:16])) - w_half + EdgeW'(xo_q);
        ymin_q <= $signed(EdgeW'(cyp_q[39:16])) - h_half + EdgeW'(yo_q);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      box_x_min_o  <= sat32(xmin_q);
      box_y_min_o  <= sat32(ymin_q);
      box_x_max_o  <= sat32(xmax);
      box_y_max_o  <= sat32(ymax);
      best_class_o <= rs_cls_q;
      best_score_o <= rs_score_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_CLASSES)
    else $error("class counter beyond limit");

  a_box_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_end |=> (best_q == '0) && (cnt_q == '0) && (bcls_q == '0))
    else $error("running maximum not cleared at box end");

  a_max_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (score_in && !last_class_i) |=> best_q >= $past(best_q))
    else $error("running maximum decreased");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> ($past(state_q) == ST_EDGE) || ($past(state_q) == ST_OUT))
    else $error("result loaded out of sequence");

endmodule

/* tb/tb_argmax_threshold_box_decode.sv */
// Self-checking testbench for the argmax threshold box decoder: random and directed words.
`timescale 1ns / 1ps

module tb_argmax_threshold_box_decode;
  import atbd_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int IdlePct    = 19;
  localparam int SettleCyc  = 12;

  typedef struct {
    logic              kind;
    logic signed [7:0] tidx;
    logic [31:0]       value;
    logic              last;
    logic signed [7:0] lx;
    logic signed [7:0] ly;
    logic signed [7:0] lw;
    logic signed [7:0] lh;
    logic [7:0]        pcx;
    logic [7:0]        pcy;
    logic [7:0]        pw;
    logic [7:0]        ph;
  } box_word_t;

  typedef struct {
    logic [31:0] xmin;
    logic [31:0] ymin;
    logic [31:0] xmax;
    logic [31:0] ymax;
    logic [7:0]  cls;
    logic [31:0] score;
  } box_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [CfgAddrW-1:0] paddr         = '0;
  logic [WordW-1:0]    pwdata        = '0;
  logic [WordW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                kind_i        = 1'b0;
  logic signed [7:0]   table_index_i = '0;
  logic [WordW-1:0]    value_i       = '0;
  logic                last_class_i  = 1'b0;
  logic signed [7:0]   loc_x_i       = '0;
  logic signed [7:0]   loc_y_i       = '0;
  logic signed [7:0]   loc_w_i       = '0;
  logic signed [7:0]   loc_h_i       = '0;
  logic [7:0]          prior_cx_i    = '0;
  logic [7:0]          prior_cy_i    = '0;
  logic [7:0]          prior_w_i     = '0;
  logic [7:0]          prior_h_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic signed [WordW-1:0] box_x_min_o;
  logic signed [WordW-1:0] box_y_min_o;
  logic signed [WordW-1:0] box_x_max_o;
  logic signed [WordW-1:0] box_y_max_o;
  logic [7:0]          best_class_o;
  logic [WordW-1:0]    best_score_o;

  box_word_t   word_q[$];
  box_result_t boxes_due[$];
  box_word_t   nxt_word;
  box_word_t   taken_word;
  logic        in_took = 1'b0;
  logic        calm    = 1'b0;
  int          quiet   = 0;

  logic [31:0] exp_mem [256];
  logic [31:0] run_score = '0;
  logic [7:0]  run_class = '0;
  int          seen_cnt  = 0;
  logic [31:0] cfg_threshold = ThresholdRst;
  logic        cfg_skip      = SkipBgRst;
  logic [31:0] cfg_size      = SizeScaleRst;
  logic [31:0] cfg_off       = OffScaleRst;
  logic [31:0] cfg_ctr       = CtrScaleRst;

  bit slot_loaded [256];
  int loaded_slots[$];

  int words_pushed   = 0;
  int words_taken    = 0;
  int table_words    = 0;
  int score_words    = 0;
  int results_seen   = 0;
  int mismatches     = 0;

  argmax_threshold_box_decode i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .table_index_i (table_index_i),
    .value_i       (value_i),
    .last_class_i  (last_class_i),
    .loc_x_i       (loc_x_i),
    .loc_y_i       (loc_y_i),
    .loc_w_i       (loc_w_i),
    .loc_h_i       (loc_h_i),
    .prior_cx_i    (prior_cx_i),
    .prior_cy_i    (prior_cy_i),
    .prior_w_i     (prior_w_i),
    .prior_h_i     (prior_h_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .box_x_min_o   (box_x_min_o),
    .box_y_min_o   (box_y_min_o),
    .box_x_max_o   (box_x_max_o),
    .box_y_max_o   (box_y_max_o),
    .best_class_o  (best_class_o),
    .best_score_o  (best_score_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint q16_trunc(input longint a, input logic [31:0] s);
    longint unsigned m;
    longint unsigned q;
    m = (a < 0) ? longint'(-a) : a;
    q = (m * s) >> 16;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return 32'(v);
  endfunction

  task automatic track_word(input box_word_t w);
    box_result_t r;
    logic [39:0] wprod;
    logic [39:0] hprod;
    logic [79:0] wide;
    longint      wd;
    longint      ht;
    longint      x;
    longint      y;
    logic [31:0] bs;
    logic [7:0]  bc;
    if (!w.kind) begin
      exp_mem[{~w.tidx[7], w.tidx[6:0]}] = w.value;
      return;
    end
    if (seen_cnt < MaxClassesDef) begin
      if (!(cfg_skip && seen_cnt == 0) && w.value > run_score) begin
        run_score = w.value;
        run_class = 8'(seen_cnt - int'(cfg_skip));
      end
      seen_cnt++;
    end
    if (!w.last) return;
    bs        = run_score;
    bc        = run_class;
    run_score = '0;
    run_class = '0;
    seen_cnt  = 0;
    if (bs < cfg_threshold) return;
    wprod = w.pw * exp_mem[{~w.lw[7], w.lw[6:0]}];
    hprod = w.ph * exp_mem[{~w.lh[7], w.lh[6:0]}];
    wide  = wprod * cfg_size;
    wd    = longint'(wide >> 16);
    wide  = hprod * cfg_size;
    ht    = longint'(wide >> 16);
    x = q16_trunc(longint'(w.pcx), cfg_ctr) - wd / 2
        + q16_trunc(longint'(w.lx) * longint'(w.pw), cfg_off);
    y = q16_trunc(longint'(w.pcy), cfg_ctr) - ht / 2
        + q16_trunc(longint'(w.ly) * longint'(w.ph), cfg_off);
    r.xmin  = clip32(x);
    r.ymin  = clip32(y);
    r.xmax  = clip32(x + wd);
    r.ymax  = clip32(y + ht);
    r.cls   = bc;
    r.score = bs;
    boxes_due.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  task automatic check_box();
    box_result_t want;
    if (boxes_due.size() == 0) begin
      report_mismatch("unexpected box score", best_score_o, '0);
      return;
    end
    want = boxes_due.pop_front();
    results_seen++;
    if (box_x_min_o !== want.xmin) report_mismatch("box_x_min", box_x_min_o, want.xmin);
    if (box_y_min_o !== want.ymin) report_mismatch("box_y_min", box_y_min_o, want.ymin);
    if (box_x_max_o !== want.xmax) report_mismatch("box_x_max", box_x_max_o, want.xmax);
    if (box_y_max_o !== want.ymax) report_mismatch("box_y_max", box_y_max_o, want.ymax);
    if (best_class_o !== want.cls) report_mismatch("best_class", best_class_o, want.cls);
    if (best_score_o !== want.score) report_mismatch("best_score", best_score_o, want.score);
  endtask

  // advance the input word only once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (word_q.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        nxt_word      = word_q.pop_front();
        kind_i        <= nxt_word.kind;
        table_index_i <= nxt_word.tidx;
        value_i       <= nxt_word.value;
        last_class_i  <= nxt_word.last;
        loc_x_i       <= nxt_word.lx;
        loc_y_i       <= nxt_word.ly;
        loc_w_i       <= nxt_word.lw;
        loc_h_i       <= nxt_word.lh;
        prior_cx_i    <= nxt_word.pcx;
        prior_cy_i    <= nxt_word.pcy;
        prior_w_i     <= nxt_word.pw;
        prior_h_i     <= nxt_word.ph;
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) check_box();
    if (rst_ni && in_valid_i && !in_stall_o) begin
      taken_word.kind  = kind_i;
      taken_word.tidx  = table_index_i;
      taken_word.value = value_i;
      taken_word.last  = last_class_i;
      taken_word.lx    = loc_x_i;
      taken_word.ly    = loc_y_i;
      taken_word.lw    = loc_w_i;
      taken_word.lh    = loc_h_i;
      taken_word.pcx   = prior_cx_i;
      taken_word.pcy   = prior_cy_i;
      taken_word.pw    = prior_w_i;
      taken_word.ph    = prior_h_i;
      track_word(taken_word);
      words_taken++;
      if (kind_i) score_words++;
      else table_words++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'(4 * int'(idx));
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_THRESHOLD:  cfg_threshold = v;
      REG_SKIP_BG:    cfg_skip      = v[0];
      REG_SIZE_SCALE: cfg_size      = v;
      REG_OFF_SCALE:  cfg_off       = v;
      REG_CTR_SCALE:  cfg_ctr       = v;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_all(input logic [31:0] thr, input logic skip, input logic [31:0] sz,
                         input logic [31:0] off, input logic [31:0] ctr);
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_SKIP_BG, {31'b0, skip});
    cfg_write(REG_SIZE_SCALE, sz);
    cfg_write(REG_OFF_SCALE, off);
    cfg_write(REG_CTR_SCALE, ctr);
  endtask

  // hold until every word is taken and every box has come out
  task automatic settle();
    while (words_taken != words_pushed) @(posedge clk_i);
    while (boxes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_delta();
    if (loaded_slots.size() == 0) return 8'h00;
    return 8'(loaded_slots[$urandom_range(loaded_slots.size() - 1)]) ^ 8'h80;
  endfunction

  function automatic logic [31:0] pick_score();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(255);
      2: return 32'hFFFF_FFFF;
      3: return cfg_threshold;
      default: return cfg_threshold - 32'd1;
    endcase
  endfunction

  function automatic logic [31:0] pick_exp();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0002_0000);
      2: return 32'h0001_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic box_word_t rand_word();
    box_word_t w;
    w.kind  = 1'b1;
    w.tidx  = 8'($urandom);
    w.value = $urandom;
    w.last  = 1'($urandom);
    w.lx    = 8'($urandom);
    w.ly    = 8'($urandom);
    w.lw    = pick_delta();
    w.lh    = pick_delta();
    w.pcx   = 8'($urandom);
    w.pcy   = 8'($urandom);
    w.pw    = 8'($urandom);
    w.ph    = 8'($urandom);
    return w;
  endfunction

  task automatic push_word(input box_word_t w);
    word_q.push_back(w);
    words_pushed++;
  endtask

  task automatic push_table(input int slot, input logic [31:0] v, input logic fin);
    box_word_t w;
    w       = rand_word();
    w.kind  = 1'b0;
    w.tidx  = 8'(slot) ^ 8'h80;
    w.value = v;
    w.last  = fin;
    push_word(w);
    if (!slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots.push_back(slot);
    end
  endtask

  task automatic push_score(input logic [31:0] v, input logic fin);
    box_word_t w;
    w       = rand_word();
    w.value = v;
    w.last  = fin;
    push_word(w);
  endtask

  task automatic push_close(input logic [31:0] v, input logic signed [7:0] lx,
                            input logic signed [7:0] ly, input logic signed [7:0] lw,
                            input logic signed [7:0] lh, input logic [7:0] prior);
    box_word_t w;
    w       = rand_word();
    w.value = v;
    w.last  = 1'b1;
    w.lx    = lx;
    w.ly    = ly;
    w.lw    = lw;
    w.lh    = lh;
    w.pcx   = prior;
    w.pcy   = prior;
    w.pw    = prior;
    w.ph    = prior;
    push_word(w);
  endtask

  task automatic push_box(input int n);
    for (int k = 0; k < n; k++) push_score(pick_score(), k == n - 1);
  endtask

  task automatic run_phase(input int n_words, input bit with_long);
    int start;
    int r;
    start = words_pushed;
    if (with_long) push_box($urandom_range(262, 257));
    while (words_pushed - start < n_words) begin
      r = $urandom_range(99);
      if (r < 20) begin
        push_table($urandom_range(255), pick_exp(), 1'($urandom));
      end else if (r < 90) begin
        push_box($urandom_range(4, 1));
      end else if (r < 98) begin
        push_box($urandom_range(16, 5));
      end else begin
        push_box($urandom_range(40, 17));
      end
    end
  endtask

  initial begin
    int s;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: table extremes, earliest best class, saturation
    push_table(0, 32'hFFFF_FFFF, 1'b0);
    push_table(255, 32'h0001_0000, 1'b0);
    push_table(128, 32'h0001_0000, 1'b0);
    push_table(129, 32'h0000_0000, 1'b0);
    push_table(127, 32'h1234_5678, 1'b0);
    push_close(32'h0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'h00);
    push_score(32'd5, 1'b0);
    push_score(32'd9, 1'b0);
    push_score(32'd9, 1'b0);
    push_close(32'd3, -8'sd128, 8'sd127, -8'sd128, 8'sd127, 8'hFF);
    push_score(32'hFFFF_FFFF, 1'b0);
    push_close(32'hFFFF_FFFF, 8'sd127, -8'sd128, -8'sd1, 8'sd1, 8'hFF);
    push_table(129, 32'h0000_0100, 1'b1);
    push_close(32'd7, 8'sd1, 8'sd2, 8'sd1, 8'sd0, 8'd100);
    settle();

    // background skip, including a box with nothing counted
    cfg_write(REG_SKIP_BG, 32'd1);
    push_close(32'h55, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'd10);
    push_score(32'd7, 1'b0);
    push_score(32'd2, 1'b0);
    push_close(32'd8, -8'sd5, 8'sd5, 8'sd0, 8'sd0, 8'd200);
    settle();

    cfg_write(REG_SKIP_BG, 32'd0);
    cfg_write(REG_THRESHOLD, 32'hFFFF_FFFF);
    push_close(32'hFFFF_FFFE, 8'sd1, 8'sd1, 8'sd0, 8'sd0, 8'd50);
    push_close(32'hFFFF_FFFF, 8'sd3, -8'sd3, -8'sd1, -8'sd128, 8'd128);
    settle();

    // fill the rest of the exp table with no idling on either side
    calm <= 1'b1;
    cfg_all(32'h0, 1'b0, SizeScaleRst, OffScaleRst, CtrScaleRst);
    while (loaded_slots.size() < 256) begin
      s = $urandom_range(255);
      if (!slot_loaded[s]) push_table(s, pick_exp(), 1'($urandom));
    end
    run_phase(150, 1'b0);
    settle();
    calm <= 1'b0;

    cfg_all(32'h8000_0000, 1'b1, 32'h0, 32'h0, 32'h0);
    run_phase(200, 1'b1);
    settle();

    cfg_all(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(200, 1'b0);
    settle();

    cfg_all($urandom_range(1000), 1'b1, $urandom_range(32'h2_0000, 32'h100),
            $urandom_range(32'h10_0000), $urandom_range(32'h10_0000));
    run_phase(200, 1'b1);
    settle();

    cfg_all($urandom, 1'($urandom), $urandom, $urandom, $urandom);
    run_phase(200, 1'b0);
    settle();

    if (boxes_due.size() != 0) report_mismatch("boxes never produced", boxes_due.size(), '0);
    $display("Covered %0d table words and %0d class scores over eight register settings,",
             table_words, score_words);
    $display("with %0d decoded boxes checked and %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/atbd_pkg.sv
hdl/argmax_threshold_box_decode.sv
tb/tb_argmax_threshold_box_decode.sv
